// ===== hw/rtl/ttl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_pkg
// Shared types and constants for the thermal throttle level controller.
// ----------------------------------------------------------------------------
package ttl_pkg;

	localparam int TEMP_W  = 8;
	localparam int BAND_W  = 16;
	localparam int CAP_W   = 22;
	localparam int LEVEL_W = 2;
	localparam int POLL_W  = 2;

	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;
	localparam int REG_IDX_W = 3;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [REG_IDX_W-1:0] {
		REG_TRIP_TEMP     = 3'd0,
		REG_LOW_BAND      = 3'd1,
		REG_MID_BAND      = 3'd2,
		REG_MAX_BAND      = 3'd3,
		REG_LOW_CAP       = 3'd4,
		REG_MID_CAP       = 3'd5,
		REG_TOP_CAP       = 3'd6,
		REG_FALLBACK_CAP  = 3'd7
	} reg_idx_t;

	localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_MAX  = 2'd3;

	localparam logic [POLL_W-1:0] POLL_NORMAL = 2'd0;
	localparam logic [POLL_W-1:0] POLL_LOW    = 2'd1;
	localparam logic [POLL_W-1:0] POLL_HIGH   = 2'd2;

	localparam logic [TEMP_W-1:0] TRIP_TEMP_RST     = 8'hFF;
	localparam logic [CAP_W-1:0]  FALLBACK_CAP_RST  = 22'h3FFFFF;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature;
		logic              sensor_error;
		logic [CAP_W-1:0]  current_limit;
	} sample_t;

	typedef struct packed {
		logic               apply_cap;
		logic [CAP_W-1:0]   cap_value;
		logic [LEVEL_W-1:0] throttle_level;
		logic               shutdown;
		logic [POLL_W-1:0]  poll_class;
	} result_t;

	typedef struct packed {
		logic [TEMP_W-1:0] trip_temp;
		logic [BAND_W-1:0] low_band;
		logic [BAND_W-1:0] mid_band;
		logic [BAND_W-1:0] max_band;
		logic [CAP_W-1:0]  low_cap;
		logic [CAP_W-1:0]  mid_cap;
		logic [CAP_W-1:0]  top_cap;
		logic [CAP_W-1:0]  fallback_cap;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [CAP_W-1:0]   saved_limit;
	} state_t;

endpackage

// ===== hw/rtl/ttl_rules.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_rules
// Hysteresis rule evaluation: new level, cap and status for one sample.
// ----------------------------------------------------------------------------
module ttl_rules (
	input  ttl_pkg::cfg_t    cfg,
	input  ttl_pkg::state_t  cur_state,
	input  ttl_pkg::sample_t sample,
	output ttl_pkg::state_t  next_state,
	output ttl_pkg::result_t result
);

	logic [ttl_pkg::TEMP_W-1:0] t;
	logic [ttl_pkg::TEMP_W-1:0] low_h, low_l, mid_h, mid_l, max_h, max_l;
	logic [ttl_pkg::LEVEL_W-1:0] lvl, lvl_next;
	logic [ttl_pkg::CAP_W-1:0] cap;
	logic [ttl_pkg::CAP_W-1:0] restore_cap;
	logic apply;

	assign t     = sample.temperature;
	assign lvl   = cur_state.level;
	assign low_h = cfg.low_band[15:8];
	assign low_l = cfg.low_band[7:0];
	assign mid_h = cfg.mid_band[15:8];
	assign mid_l = cfg.mid_band[7:0];
	assign max_h = cfg.max_band[15:8];
	assign max_l = cfg.max_band[7:0];

	// saved limit is only consulted when already throttled; holds the pre-throttle limit
	assign restore_cap = (cur_state.saved_limit != '0) ? cur_state.saved_limit
		: cfg.fallback_cap;

	always_comb begin
		apply    = 1'b0;
		cap      = '0;
		lvl_next = lvl;
		priority if (t >= low_h && t < mid_h && lvl == ttl_pkg::LVL_NONE) begin
			apply = 1'b1; cap = cfg.low_cap; lvl_next = ttl_pkg::LVL_LOW;
		end else if (t < low_l && lvl != ttl_pkg::LVL_NONE) begin
			apply = 1'b1; cap = restore_cap; lvl_next = ttl_pkg::LVL_NONE;
		end else if (t >= mid_h && t < max_h &&
				(lvl == ttl_pkg::LVL_NONE || lvl == ttl_pkg::LVL_LOW)) begin
			apply = 1'b1; cap = cfg.mid_cap; lvl_next = ttl_pkg::LVL_MID;
		end else if (t < mid_l && (lvl == ttl_pkg::LVL_MID || lvl == ttl_pkg::LVL_MAX)) begin
			apply = 1'b1; cap = cfg.low_cap; lvl_next = ttl_pkg::LVL_LOW;
		end else if (t >= max_h) begin
			apply = 1'b1; cap = cfg.top_cap; lvl_next = ttl_pkg::LVL_MAX;
		end else if (t < max_l && lvl == ttl_pkg::LVL_MAX) begin
			apply = 1'b1; cap = cfg.mid_cap; lvl_next = ttl_pkg::LVL_MID;
		end else begin
			apply = 1'b0;
		end
	end

	always_comb begin
		if (sample.sensor_error) begin
			next_state            = cur_state;
			result.apply_cap      = 1'b0;
			result.cap_value      = '0;
			result.throttle_level = lvl;
			result.shutdown       = 1'b0;
			result.poll_class     = ttl_pkg::POLL_HIGH;
		end else begin
			next_state.level       = lvl_next;
			next_state.saved_limit = (lvl == ttl_pkg::LVL_NONE) ? sample.current_limit
				: cur_state.saved_limit;
			result.apply_cap      = apply;
			result.cap_value      = cap;
			result.throttle_level = lvl_next;
			result.shutdown       = (t >= cfg.trip_temp);
			unique case (lvl_next)
				ttl_pkg::LVL_NONE: result.poll_class = ttl_pkg::POLL_NORMAL;
				ttl_pkg::LVL_LOW:  result.poll_class = ttl_pkg::POLL_LOW;
				default:           result.poll_class = ttl_pkg::POLL_HIGH;
			endcase
		end
	end

endmodule

// ===== hw/rtl/thermal_throttle_levels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_throttle_levels
// Thermal throttle level controller: per-sample hysteresis over three
// temperature bands, frequency cap selection and shutdown flag.
//
//   channel | signals                        | carries
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data    | sample request (ttl_pkg::sample_t)
//   out     | out_valid, out_ready, out_data | result (ttl_pkg::result_t)
//   apb     | psel .. pready                 | register write / read
//
// One sample per cycle sustained while the output is not stalled; samples pass
// through the input register, then rule logic into the result register.
// Level and saved limit update in the cycle the result register loads.
// A stalled output holds its result; the input register still takes one more
// request, after which in_ready drops until the output drains.
// Reset clears level, saved limit and registers to their reset values.
// ----------------------------------------------------------------------------
module thermal_throttle_levels (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ttl_pkg::sample_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ttl_pkg::result_t              out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ttl_pkg::APB_AW-1:0]    paddr,
	input  logic [ttl_pkg::APB_DW-1:0]    pwdata,
	output logic [ttl_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	ttl_pkg::cfg_t    cfg_q;
	ttl_pkg::state_t  state_q;
	ttl_pkg::state_t  state_next;
	ttl_pkg::sample_t sample_s1;
	ttl_pkg::result_t result_next;
	ttl_pkg::result_t result_q;
	ttl_pkg::reg_idx_t reg_idx;
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic wr_en;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign reg_idx = ttl_pkg::reg_idx_t'(paddr[ttl_pkg::APB_AW-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trip_temp     <= ttl_pkg::TRIP_TEMP_RST;
			cfg_q.low_band      <= '0;
			cfg_q.mid_band      <= '0;
			cfg_q.max_band      <= '0;
			cfg_q.low_cap       <= '0;
			cfg_q.mid_cap       <= '0;
			cfg_q.top_cap       <= '0;
			cfg_q.fallback_cap  <= ttl_pkg::FALLBACK_CAP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				ttl_pkg::REG_TRIP_TEMP:     cfg_q.trip_temp     <= pwdata[ttl_pkg::TEMP_W-1:0];
				ttl_pkg::REG_LOW_BAND:      cfg_q.low_band      <= pwdata[ttl_pkg::BAND_W-1:0];
				ttl_pkg::REG_MID_BAND:      cfg_q.mid_band      <= pwdata[ttl_pkg::BAND_W-1:0];
				ttl_pkg::REG_MAX_BAND:      cfg_q.max_band      <= pwdata[ttl_pkg::BAND_W-1:0];
				ttl_pkg::REG_LOW_CAP:       cfg_q.low_cap       <= pwdata[ttl_pkg::CAP_W-1:0];
				ttl_pkg::REG_MID_CAP:       cfg_q.mid_cap       <= pwdata[ttl_pkg::CAP_W-1:0];
				ttl_pkg::REG_TOP_CAP:       cfg_q.top_cap       <= pwdata[ttl_pkg::CAP_W-1:0];
				ttl_pkg::REG_FALLBACK_CAP:  cfg_q.fallback_cap  <= pwdata[ttl_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ttl_pkg::REG_TRIP_TEMP:     prdata[ttl_pkg::TEMP_W-1:0] = cfg_q.trip_temp;
			ttl_pkg::REG_LOW_BAND:      prdata[ttl_pkg::BAND_W-1:0] = cfg_q.low_band;
			ttl_pkg::REG_MID_BAND:      prdata[ttl_pkg::BAND_W-1:0] = cfg_q.mid_band;
			ttl_pkg::REG_MAX_BAND:      prdata[ttl_pkg::BAND_W-1:0] = cfg_q.max_band;
			ttl_pkg::REG_LOW_CAP:       prdata[ttl_pkg::CAP_W-1:0]  = cfg_q.low_cap;
			ttl_pkg::REG_MID_CAP:       prdata[ttl_pkg::CAP_W-1:0]  = cfg_q.mid_cap;
			ttl_pkg::REG_TOP_CAP:       prdata[ttl_pkg::CAP_W-1:0]  = cfg_q.top_cap;
			ttl_pkg::REG_FALLBACK_CAP:  prdata[ttl_pkg::CAP_W-1:0]  = cfg_q.fallback_cap;
			default: prdata = '0;
		endcase
	end

	// ---------------- datapath ----------------
	// stage 1 moves into the result register when that register is free or draining
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_data;
		end
	end

	ttl_rules u_rules (
		.cfg        (cfg_q),
		.cur_state  (state_q),
		.sample     (sample_s1),
		.next_state (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.level       <= ttl_pkg::LVL_NONE;
			state_q.saved_limit <= '0;
			out_valid_q         <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// ---------------- assertions ----------------
	a_err_keeps_level: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && sample_s1.sensor_error) |=> (state_q == $past(state_q)))
		else $error("sensor error request changed state");

	a_cap_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_q.apply_cap) |-> (result_q.cap_value == '0))
		else $error("cap_value nonzero without apply_cap");

	a_level_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.throttle_level == state_q.level))
		else $error("reported level differs from stored level");

	a_poll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.poll_class == ttl_pkg::POLL_NORMAL ||
			result_q.poll_class == ttl_pkg::POLL_LOW ||
			result_q.poll_class == ttl_pkg::POLL_HIGH))
		else $error("poll_class out of range");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(result_q) &&
			$stable(state_q)))
		else $error("stalled result overwritten");

endmodule
